[hw/rtl/tlq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlq_pkg: shared types, widths and helpers of the thick line quad expander
// Holds the fixed-point widths, the payload structs that travel down the
// pipeline and the saturating corner adder.
// ----------------------------------------------------------------------------
package tlq_pkg;

  localparam int COORD_BITS  = 24;
  localparam int WIDTH_BITS  = 16;
  localparam int COLOUR_BITS = 32;

  // Endpoint difference, its square sum and the scaled numerator.
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * DELTA_BITS;
  localparam int P_BITS     = DELTA_BITS + WIDTH_BITS;
  localparam int P_LO_BITS  = (P_BITS + 1) / 2;
  localparam int P_HI_BITS  = P_BITS - P_LO_BITS;
  localparam int P2_BITS    = 2 * P_BITS;

  // Offset magnitude: one result bit per search step.
  localparam int MAG_BITS = WIDTH_BITS;
  localparam int ACC_BITS = SQ_BITS + 2 * MAG_BITS + 6;
  localparam int SUM_BITS = COORD_BITS + 2;

  localparam int IN_BITS  = 4 * COORD_BITS + WIDTH_BITS + COLOUR_BITS;
  localparam int OUT_BITS = 8 * COORD_BITS + COLOUR_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;

  typedef struct packed {
    coord_t                 ax;
    coord_t                 ay;
    coord_t                 bx;
    coord_t                 by;
    logic                   neg_x;
    logic                   neg_y;
    logic [COLOUR_BITS-1:0] colour;
  } geom_t;

  // q: sq*t^2 of the accepted prefix, c: cross term, a: square term.
  typedef struct packed {
    geom_t               geom;
    logic [P2_BITS-1:0]  p2x;
    logic [P2_BITS-1:0]  p2y;
    acc_t                qx;
    acc_t                qy;
    acc_t                cx;
    acc_t                cy;
    acc_t                a;
    logic [MAG_BITS-1:0] mx;
    logic [MAG_BITS-1:0] my;
  } srch_t;

  function automatic coord_t add_sat(coord_t c, logic [MAG_BITS-1:0] mag, logic sub);
    logic signed [SUM_BITS-1:0] ce;
    logic signed [SUM_BITS-1:0] me;
    logic signed [SUM_BITS-1:0] s;
    logic signed [SUM_BITS-1:0] mx;
    logic signed [SUM_BITS-1:0] mn;
    ce = {{(SUM_BITS-COORD_BITS){c[COORD_BITS-1]}}, c};
    me = $signed({{(SUM_BITS-MAG_BITS){1'b0}}, mag});
    s  = sub ? ce - me : ce + me;
    mx = $signed({{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
    mn = -mx - $signed(SUM_BITS'(1));
    if (s > mx) begin
      s = mx;
    end else if (s < mn) begin
      s = mn;
    end
    return s[COORD_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/tlq_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlq_front: four-stage front end of the thick line quad expander
// Forms the endpoint difference, its squares, the scaled numerators and their
// squares, and seeds the offset search.
// ----------------------------------------------------------------------------
module tlq_front import tlq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [IN_BITS-1:0]  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output srch_t                    out_data_o
);

  logic [3:0] valid_q;
  logic [3:0] adv;

  assign adv[3] = !valid_q[3] || out_ready_i;
  assign adv[2] = !valid_q[2] || adv[3];
  assign adv[1] = !valid_q[1] || adv[2];
  assign adv[0] = !valid_q[0] || adv[1];
  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[3];

  // Stage 1: differences and drop test.
  coord_t                  sx, sy, ex, ey;
  logic [WIDTH_BITS-1:0]   w;
  logic signed [DELTA_BITS-1:0] dx, dy;
  logic                    keep;
  geom_t                   geom_d;

  assign sx = in_data_i[COORD_BITS-1:0];
  assign sy = in_data_i[2*COORD_BITS-1:COORD_BITS];
  assign ex = in_data_i[3*COORD_BITS-1:2*COORD_BITS];
  assign ey = in_data_i[4*COORD_BITS-1:3*COORD_BITS];
  assign w  = in_data_i[4*COORD_BITS+WIDTH_BITS-1:4*COORD_BITS];
  assign dx = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
  assign dy = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
  assign keep = (w != '0) && ((dx != '0) || (dy != '0));

  always_comb begin
    geom_d.ax     = sx;
    geom_d.ay     = sy;
    geom_d.bx     = ex;
    geom_d.by     = ey;
    geom_d.neg_x  = !dy[DELTA_BITS-1] && (dy != '0);
    geom_d.neg_y  = dx[DELTA_BITS-1];
    geom_d.colour = in_data_i[IN_BITS-1:4*COORD_BITS+WIDTH_BITS];
  end

  geom_t                  geom1_q, geom2_q, geom3_q;
  logic [DELTA_BITS-1:0]  adx1_q, ady1_q;
  logic [WIDTH_BITS-1:0]  w1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      geom1_q <= geom_d;
      adx1_q  <= dx[DELTA_BITS-1] ? DELTA_BITS'(-dx) : DELTA_BITS'(dx);
      ady1_q  <= dy[DELTA_BITS-1] ? DELTA_BITS'(-dy) : DELTA_BITS'(dy);
      w1_q    <= w;
    end
  end

  // Stage 2: squares and scaled numerators.
  logic [SQ_BITS-1:0] sqx2_q, sqy2_q;
  logic [P_BITS-1:0]  px2_q, py2_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      geom2_q <= geom1_q;
      sqx2_q  <= SQ_BITS'(adx1_q) * SQ_BITS'(adx1_q);
      sqy2_q  <= SQ_BITS'(ady1_q) * SQ_BITS'(ady1_q);
      px2_q   <= P_BITS'(ady1_q) * P_BITS'(w1_q);
      py2_q   <= P_BITS'(adx1_q) * P_BITS'(w1_q);
    end
  end

  // Stage 3: length square and partial products of the numerator squares.
  logic [SQ_BITS-1:0]             sq3_q;
  logic [2*P_HI_BITS-1:0]         hhx3_q, hhy3_q;
  logic [P_HI_BITS+P_LO_BITS-1:0] hlx3_q, hly3_q;
  logic [2*P_LO_BITS-1:0]         llx3_q, lly3_q;
  logic [P_HI_BITS-1:0]           phx, phy;
  logic [P_LO_BITS-1:0]           plx, ply;

  assign phx = px2_q[P_BITS-1:P_LO_BITS];
  assign plx = px2_q[P_LO_BITS-1:0];
  assign phy = py2_q[P_BITS-1:P_LO_BITS];
  assign ply = py2_q[P_LO_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      geom3_q <= geom2_q;
      sq3_q   <= sqx2_q + sqy2_q;
      hhx3_q  <= (2*P_HI_BITS)'(phx) * (2*P_HI_BITS)'(phx);
      hhy3_q  <= (2*P_HI_BITS)'(phy) * (2*P_HI_BITS)'(phy);
      hlx3_q  <= (P_HI_BITS+P_LO_BITS)'(phx) * (P_HI_BITS+P_LO_BITS)'(plx);
      hly3_q  <= (P_HI_BITS+P_LO_BITS)'(phy) * (P_HI_BITS+P_LO_BITS)'(ply);
      llx3_q  <= (2*P_LO_BITS)'(plx) * (2*P_LO_BITS)'(plx);
      lly3_q  <= (2*P_LO_BITS)'(ply) * (2*P_LO_BITS)'(ply);
    end
  end

  // Stage 4: numerator squares and search seed for the top result bit.
  acc_t  sq_ext;
  srch_t seed_d;
  srch_t seed_q;

  assign sq_ext = $signed({{(ACC_BITS-SQ_BITS){1'b0}}, sq3_q});

  always_comb begin
    seed_d.geom = geom3_q;
    seed_d.p2x  = (P2_BITS'(hhx3_q) << (2*P_LO_BITS))
                + (P2_BITS'(hlx3_q) << (P_LO_BITS+1)) + P2_BITS'(llx3_q);
    seed_d.p2y  = (P2_BITS'(hhy3_q) << (2*P_LO_BITS))
                + (P2_BITS'(hly3_q) << (P_LO_BITS+1)) + P2_BITS'(lly3_q);
    seed_d.qx   = sq_ext;
    seed_d.qy   = sq_ext;
    seed_d.cx   = -(sq_ext <<< (MAG_BITS+1));
    seed_d.cy   = -(sq_ext <<< (MAG_BITS+1));
    seed_d.a    = sq_ext <<< (2*MAG_BITS);
    seed_d.mx   = '0;
    seed_d.my   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      seed_q <= seed_d;
    end
  end

  assign out_data_o = seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i && keep;
      if (adv[1]) valid_q[1] <= valid_q[0];
      if (adv[2]) valid_q[2] <= valid_q[1];
      if (adv[3]) valid_q[3] <= valid_q[2];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tlq_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlq_step: one result bit of the offset magnitude search
// Tries to set the next bit of each magnitude by comparing the length square
// times the squared odd bound against the numerator square.
// ----------------------------------------------------------------------------
module tlq_step import tlq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire srch_t in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output srch_t      out_data_o
);

  logic  valid_q;
  srch_t data_q;
  srch_t nxt;
  acc_t  try_x, try_y;
  logic  ok_x, ok_y;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    try_x = in_data_i.qx + in_data_i.cx + in_data_i.a;
    try_y = in_data_i.qy + in_data_i.cy + in_data_i.a;
    ok_x  = try_x <= $signed({{(ACC_BITS-P2_BITS){1'b0}}, in_data_i.p2x});
    ok_y  = try_y <= $signed({{(ACC_BITS-P2_BITS){1'b0}}, in_data_i.p2y});
    nxt      = in_data_i;
    nxt.qx   = ok_x ? try_x : in_data_i.qx;
    nxt.qy   = ok_y ? try_y : in_data_i.qy;
    nxt.cx   = (ok_x ? in_data_i.cx + (in_data_i.a <<< 1) : in_data_i.cx) >>> 1;
    nxt.cy   = (ok_y ? in_data_i.cy + (in_data_i.a <<< 1) : in_data_i.cy) >>> 1;
    nxt.a    = in_data_i.a >>> 2;
    nxt.mx   = {in_data_i.mx[MAG_BITS-2:0], ok_x};
    nxt.my   = {in_data_i.my[MAG_BITS-2:0], ok_y};
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      data_q <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tlq_corner.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlq_corner: corner formation and output register
// Applies the signed offset to both endpoints with saturation and holds the
// packed result until the receiver takes it.
// ----------------------------------------------------------------------------
module tlq_corner import tlq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire srch_t               in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OUT_BITS-1:0]      out_data_o
);

  logic                valid_q;
  logic [OUT_BITS-1:0] data_q;
  logic [OUT_BITS-1:0] data_d;
  geom_t               g;

  assign g           = in_data_i.geom;
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    data_d = {g.colour,
              add_sat(g.ay, in_data_i.my, !g.neg_y),
              add_sat(g.ax, in_data_i.mx, !g.neg_x),
              add_sat(g.by, in_data_i.my, !g.neg_y),
              add_sat(g.bx, in_data_i.mx, !g.neg_x),
              add_sat(g.by, in_data_i.my, g.neg_y),
              add_sat(g.bx, in_data_i.mx, g.neg_x),
              add_sat(g.ay, in_data_i.my, g.neg_y),
              add_sat(g.ax, in_data_i.mx, g.neg_x)};
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/thick_line_quad_expand.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thick_line_quad_expand: line segment to thick-line quad corners
// Streams segments in and quads out, one transaction per cycle unless the master side stalls.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one segment per transaction: both endpoints, the
// line thickness and a packed colour. The master stream carries the four
// quad corners (start+n, end+n, end-n, start-n) and the unchanged colour.
// A segment with zero thickness or coincident endpoints yields no output.
// The offset magnitudes are found exactly, one result bit per pipeline
// stage; a result passes four front-end stages, sixteen search stages and
// the corner register. Throughput is one segment per cycle unless the
// master side stalls; the per-bit search stage sets it.
// Every stage holds a valid bit and takes new data whenever it is empty or
// its successor moves, so bubbles collapse and a stall on the master side
// backs up stage by stage without losing or repeating a transaction.
// The slave side keeps accepting while a finished result waits, as long as
// some stage is empty.
// Reset clears all valid bits; the pipeline comes out of reset empty and
// ready.
// ----------------------------------------------------------------------------
module thick_line_quad_expand import tlq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // start_x, start_y, end_x, end_y, line_width, colour_in (lowest bit up)
  input  wire logic [IN_BITS-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y, colour_out (lowest bit up)
  output logic [OUT_BITS-1:0]      m_axis_tdata
);

  // Handshake between the search stages; entry 0 is the front end output.
  srch_t                stg_data  [MAG_BITS+1];
  logic [MAG_BITS:0]    stg_valid;
  logic [MAG_BITS:0]    stg_ready;

  tlq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (stg_valid[0]),
    .out_ready_i (stg_ready[0]),
    .out_data_o  (stg_data[0])
  );

  // One stage per magnitude bit, most significant bit first.
  for (genvar k = 0; k < MAG_BITS; k++) begin : g_step
    tlq_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[k]),
      .in_ready_o  (stg_ready[k]),
      .in_data_i   (stg_data[k]),
      .out_valid_o (stg_valid[k+1]),
      .out_ready_i (stg_ready[k+1]),
      .out_data_o  (stg_data[k+1])
    );
  end

  tlq_corner u_corner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[MAG_BITS]),
    .in_ready_o  (stg_ready[MAG_BITS]),
    .in_data_i   (stg_data[MAG_BITS]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // An empty output register means every stage can move, so input is open.
  a_empty_out_opens_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output register is empty");

  // A ready receiver frees the whole chain.
  a_ready_out_opens_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while receiver is ready");

  // After reset the pipeline starts empty.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
